// File: rtl/lzsd_pkg.sv
// Shared types and constants for the LZSS stream decompressor.
package lzsd_pkg;

   localparam int WINDOW_DEPTH   = 4096;
   localparam int WIN_ADDR_W     = $clog2(WINDOW_DEPTH);
   localparam int TOKENS_PER_FLAG = 8;
   localparam int CMDQ_DEPTH     = 4;
   localparam int CMDQ_PTR_W     = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W     = CMDQ_PTR_W + 1;
   localparam int MAX_RESULTS    = 31;
   localparam int LEN_BIAS_W     = 5;
   localparam int OUT_SIZE_W     = 29;
   localparam int CSR_DATA_W     = 29;
   localparam int CSR_INDEX_W    = 1;
   localparam int MATCH_LEN_W    = 5;
   localparam int DIST_W         = 12;

   localparam logic [LEN_BIAS_W-1:0] LEN_BIAS_RESET = 5'd2;
   localparam logic [LEN_BIAS_W-1:0] LEN_BIAS_LO    = 5'd1;
   localparam logic [LEN_BIAS_W-1:0] LEN_BIAS_HI    = 5'd16;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEN_BIAS    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_SIZE = 1'd1;

   // result status codes
   localparam logic [1:0] ST_DATA      = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_status;
      logic       out_last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_LIT,
      CMD_MATCH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   last;
      logic [7:0]             data;
      logic [MATCH_LEN_W-1:0] len;
      logic [DIST_W-1:0]      distance;
   } cmd_type;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_SECOND
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WRITE,
      BK_EXHAUST
   } back_state_type;

endpackage

// File: rtl/lzsd_front.sv
// Token parser: turns compressed bytes into literal/match/no-op commands.
module lzsd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  lzsd_pkg::req_payload_type          req_payload,
   input  logic [lzsd_pkg::LEN_BIAS_W-1:0]    len_bias,
   input  logic                               q_full,
   output logic                               cmd_push,
   output lzsd_pkg::cmd_type                  cmd
);

   lzsd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          flag_ff, flag_in;
   logic [3:0]          tok_idx_ff, tok_idx_in;
   logic [7:0]          first_ff, first_in;

   logic [lzsd_pkg::LEN_BIAS_W-1:0] mm_clamped;
   logic [3:0]                      tok_next;
   logic                            group_done;

   assign cmd_push = req_valid && !q_full;
   assign tok_next = tok_idx_ff + 4'd1;
   assign group_done = (tok_next >= 4'(lzsd_pkg::TOKENS_PER_FLAG));

   always_comb begin
      if (len_bias < lzsd_pkg::LEN_BIAS_LO) begin
         mm_clamped = lzsd_pkg::LEN_BIAS_LO;
      end else if (len_bias > lzsd_pkg::LEN_BIAS_HI) begin
         mm_clamped = lzsd_pkg::LEN_BIAS_HI;
      end else begin
         mm_clamped = len_bias;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      flag_in    = flag_ff;
      tok_idx_in = tok_idx_ff;
      first_in   = first_ff;
      cmd.kind   = lzsd_pkg::CMD_NOP;
      cmd.last   = req_payload.in_last;
      cmd.data   = req_payload.in_byte;
      cmd.len    = {1'b0, first_ff[3:0]} + mm_clamped;
      cmd.distance = {req_payload.in_byte, first_ff[7:4]};
      case (phase_ff)
         lzsd_pkg::PH_FLAG: begin
            flag_in    = req_payload.in_byte;
            tok_idx_in = 4'd0;
            phase_in   = lzsd_pkg::PH_TOKEN;
         end
         lzsd_pkg::PH_TOKEN: begin
            if (flag_ff[0]) begin
               cmd.kind   = lzsd_pkg::CMD_LIT;
               flag_in    = flag_ff >> 1;
               tok_idx_in = group_done ? 4'(lzsd_pkg::TOKENS_PER_FLAG) : tok_next;
               phase_in   = group_done ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_TOKEN;
            end else begin
               first_in = req_payload.in_byte;
               phase_in = lzsd_pkg::PH_SECOND;
            end
         end
         lzsd_pkg::PH_SECOND: begin
            cmd.kind   = lzsd_pkg::CMD_MATCH;
            flag_in    = flag_ff >> 1;
            tok_idx_in = group_done ? 4'(lzsd_pkg::TOKENS_PER_FLAG) : tok_next;
            phase_in   = group_done ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_TOKEN;
         end
         default: begin
            phase_in = lzsd_pkg::PH_FLAG;
         end
      endcase
      // end of compressed input always rearms the parser
      if (req_payload.in_last) begin
         phase_in   = lzsd_pkg::PH_FLAG;
         flag_in    = 8'd0;
         tok_idx_in = 4'(lzsd_pkg::TOKENS_PER_FLAG);
         first_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lzsd_pkg::PH_FLAG;
         flag_ff    <= 8'd0;
         tok_idx_ff <= 4'(lzsd_pkg::TOKENS_PER_FLAG);
         first_ff   <= 8'd0;
      end else if (cmd_push) begin
         phase_ff   <= phase_in;
         flag_ff    <= flag_in;
         tok_idx_ff <= tok_idx_in;
         first_ff   <= first_in;
      end
   end

endmodule

// File: rtl/lzsd_cmdq.sv
// Small command queue between the parser and the copy engine.
module lzsd_cmdq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lzsd_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output lzsd_pkg::cmd_type  head_cmd
);

   lzsd_pkg::cmd_type                  entry_ff [lzsd_pkg::CMDQ_DEPTH];
   logic [lzsd_pkg::CMDQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lzsd_pkg::CMDQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lzsd_pkg::CMDQ_CNT_W-1:0]    count_ff, count_in;
   logic                               do_push, do_pop;

   assign full       = (count_ff == lzsd_pkg::CMDQ_CNT_W'(lzsd_pkg::CMDQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/lzsd_back.sv
// Copy engine: history ring, output counting, status results and output register.
module lzsd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  lzsd_pkg::cmd_type                 cmd,
   output logic                              cmd_pop,
   input  logic [lzsd_pkg::OUT_SIZE_W-1:0]   output_size,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lzsd_pkg::rsp_payload_type         rsp_payload
);

   localparam int AW = lzsd_pkg::WIN_ADDR_W;
   localparam int CW = lzsd_pkg::OUT_SIZE_W;
   localparam int LW = lzsd_pkg::MATCH_LEN_W;

   lzsd_pkg::back_state_type  state_ff, state_in;
   logic [CW-1:0]             produced_ff, produced_in;
   logic                      finished_ff, finished_in;
   logic                      out_valid_ff, out_valid_in;
   lzsd_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic [LW-1:0]             mlen_ff, mlen_in;
   logic [lzsd_pkg::DIST_W-1:0] mdist_ff, mdist_in;
   logic                      mlast_ff, mlast_in;
   logic [LW-1:0]             copy_cnt_ff, copy_cnt_in;
   logic [7:0]                rd_data_ff;

   logic [7:0]                hist_mem [lzsd_pkg::WINDOW_DEPTH];
   logic                      hist_we;
   logic [7:0]                hist_wdata;
   logic [AW-1:0]             src_addr;

   logic                      can_load;
   logic [CW:0]               prod_inc;
   logic                      reach_end;
   logic                      done_now;
   logic                      dist_bad;
   logic                      final_copy;
   logic                      emit;

   // shared decode
   always_comb begin
      can_load   = !out_valid_ff || !rsp_stall;
      prod_inc   = {1'b0, produced_ff} + 1'b1;
      reach_end  = (prod_inc >= {1'b0, output_size});
      done_now   = finished_ff || (produced_ff >= output_size);
      dist_bad   = ((CW+1)'(cmd.distance) + 1'b1) > {1'b0, produced_ff};
      final_copy = (copy_cnt_ff == mlen_ff - 1'b1);
      src_addr   = produced_ff[AW-1:0] - mdist_ff - 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzsd_pkg::BK_IDLE: begin
            if (cmd_valid && !done_now && can_load) begin
               if (cmd.kind == lzsd_pkg::CMD_LIT && !reach_end && cmd.last) begin
                  state_in = lzsd_pkg::BK_EXHAUST;
               end
            end
            if (cmd_valid && !done_now && cmd.kind == lzsd_pkg::CMD_MATCH && !dist_bad) begin
               state_in = lzsd_pkg::BK_READ;
            end
         end
         lzsd_pkg::BK_READ: begin
            state_in = lzsd_pkg::BK_WRITE;
         end
         lzsd_pkg::BK_WRITE: begin
            if (can_load) begin
               if (reach_end) begin
                  state_in = lzsd_pkg::BK_IDLE;
               end else if (final_copy) begin
                  if (mlast_ff && mlen_ff != LW'(lzsd_pkg::MAX_RESULTS)) begin
                     state_in = lzsd_pkg::BK_EXHAUST;
                  end else begin
                     state_in = lzsd_pkg::BK_IDLE;
                  end
               end else begin
                  state_in = lzsd_pkg::BK_READ;
               end
            end
         end
         lzsd_pkg::BK_EXHAUST: begin
            if (can_load) begin
               state_in = lzsd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = lzsd_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      hist_we     = 1'b0;
      hist_wdata  = cmd.data;
      produced_in = produced_ff;
      finished_in = finished_ff;
      out_data_in = out_data_ff;
      mlen_in     = mlen_ff;
      mdist_in    = mdist_ff;
      mlast_in    = mlast_ff;
      copy_cnt_in = copy_cnt_ff;
      case (state_ff)
         lzsd_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               if (done_now) begin
                  // stream over: drop input until its last byte
                  cmd_pop     = 1'b1;
                  finished_in = 1'b1;
                  if (cmd.last) begin
                     produced_in = '0;
                     finished_in = 1'b0;
                  end
               end else begin
                  case (cmd.kind)
                     lzsd_pkg::CMD_LIT: begin
                        if (can_load) begin
                           cmd_pop     = 1'b1;
                           emit        = 1'b1;
                           hist_we     = 1'b1;
                           out_data_in = '{out_byte: cmd.data, out_status: lzsd_pkg::ST_DATA,
                                           out_last: reach_end};
                           produced_in = prod_inc[CW-1:0];
                           if (reach_end) begin
                              finished_in = 1'b1;
                              if (cmd.last) begin
                                 produced_in = '0;
                                 finished_in = 1'b0;
                              end
                           end
                        end
                     end
                     lzsd_pkg::CMD_MATCH: begin
                        if (dist_bad) begin
                           if (can_load) begin
                              cmd_pop     = 1'b1;
                              emit        = 1'b1;
                              out_data_in = '{out_byte: 8'd0,
                                              out_status: lzsd_pkg::ST_MALFORMED,
                                              out_last: 1'b1};
                              finished_in = 1'b1;
                              if (cmd.last) begin
                                 produced_in = '0;
                                 finished_in = 1'b0;
                              end
                           end
                        end else begin
                           cmd_pop     = 1'b1;
                           mlen_in     = cmd.len;
                           mdist_in    = cmd.distance;
                           mlast_in    = cmd.last;
                           copy_cnt_in = '0;
                        end
                     end
                     default: begin
                        // flag byte or first match byte
                        if (!cmd.last) begin
                           cmd_pop = 1'b1;
                        end else if (can_load) begin
                           cmd_pop     = 1'b1;
                           emit        = 1'b1;
                           out_data_in = '{out_byte: 8'd0,
                                           out_status: lzsd_pkg::ST_EXHAUSTED,
                                           out_last: 1'b1};
                           produced_in = '0;
                           finished_in = 1'b0;
                        end
                     end
                  endcase
               end
            end
         end
         lzsd_pkg::BK_READ: begin
            // history read issued in the clocked block
         end
         lzsd_pkg::BK_WRITE: begin
            hist_wdata = rd_data_ff;
            if (can_load) begin
               emit        = 1'b1;
               hist_we     = 1'b1;
               produced_in = prod_inc[CW-1:0];
               copy_cnt_in = copy_cnt_ff + 1'b1;
               out_data_in = '{out_byte: rd_data_ff, out_status: lzsd_pkg::ST_DATA,
                               out_last: reach_end};
               if (reach_end) begin
                  finished_in = 1'b1;
                  if (mlast_ff) begin
                     produced_in = '0;
                     finished_in = 1'b0;
                  end
               end else if (final_copy && mlast_ff &&
                            mlen_ff == LW'(lzsd_pkg::MAX_RESULTS)) begin
                  // full-length match on the last input byte: tag the final data byte
                  out_data_in.out_status = lzsd_pkg::ST_EXHAUSTED;
                  out_data_in.out_last   = 1'b1;
                  produced_in            = '0;
                  finished_in            = 1'b0;
               end
            end
         end
         lzsd_pkg::BK_EXHAUST: begin
            if (can_load) begin
               emit        = 1'b1;
               out_data_in = '{out_byte: 8'd0, out_status: lzsd_pkg::ST_EXHAUSTED,
                               out_last: 1'b1};
               produced_in = '0;
               finished_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      out_valid_in = emit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzsd_pkg::BK_IDLE;
         produced_ff  <= '0;
         finished_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mlast_ff     <= 1'b0;
         copy_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         produced_ff  <= produced_in;
         finished_ff  <= finished_in;
         out_valid_ff <= out_valid_in;
         mlast_ff     <= mlast_in;
         copy_cnt_ff  <= copy_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      mlen_ff     <= mlen_in;
      mdist_ff    <= mdist_in;
   end

   // history ring: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[produced_ff[AW-1:0]] <= hist_wdata;
      end
      if (state_ff == lzsd_pkg::BK_READ) begin
         rd_data_ff <= hist_mem[src_addr];
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

// File: rtl/lzss_stream_decompressor.sv
// Top level of the LZSS stream decompressor: registers, parser, queue, copy engine.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall lzsd_pkg::req_payload_type (in_byte, in_last)
//   rsp_      out        rsp_valid/rsp_stall lzsd_pkg::rsp_payload_type (out_byte, out_status,
//                                                                        out_last)
//   csr_      in         csr_we              csr_index, csr_wdata
//
// The parser takes one compressed byte per cycle while the 4-entry command queue has room.
// The copy engine takes a literal or no-op byte straight from its idle state; for a match,
// each copied byte is a registered history read in BK_READ followed by the write of that same byte.
// A match therefore holds the engine from its start in BK_IDLE until all of its bytes are written.
// Synchronous active-high reset; the history ring is not cleared and needs no pass.
// A stalled rsp_ holds the engine, and the full queue then raises req_stall.
module lzss_stream_decompressor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lzsd_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lzsd_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [lzsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lzsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [lzsd_pkg::LEN_BIAS_W-1:0]  len_bias_ff, len_bias_in;
   logic [lzsd_pkg::OUT_SIZE_W-1:0]  output_size_ff, output_size_in;

   logic              q_full;
   logic              cmd_push;
   lzsd_pkg::cmd_type push_cmd;
   logic              head_valid;
   lzsd_pkg::cmd_type head_cmd;
   logic              cmd_pop;

   always_comb begin
      len_bias_in    = len_bias_ff;
      output_size_in = output_size_ff;
      if (csr_we) begin
         case (csr_index)
            lzsd_pkg::CSR_LEN_BIAS:    len_bias_in = csr_wdata[lzsd_pkg::LEN_BIAS_W-1:0];
            lzsd_pkg::CSR_OUTPUT_SIZE: output_size_in = csr_wdata[lzsd_pkg::OUT_SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_bias_ff    <= lzsd_pkg::LEN_BIAS_RESET;
         output_size_ff <= '0;
      end else begin
         len_bias_ff    <= len_bias_in;
         output_size_ff <= output_size_in;
      end
   end

   assign req_stall = q_full;

   lzsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .len_bias    (len_bias_ff),
      .q_full      (q_full),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   lzsd_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .pop        (cmd_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lzsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd         (head_cmd),
      .cmd_pop     (cmd_pop),
      .output_size (output_size_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // every status result closes the stream
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out_status == lzsd_pkg::ST_MALFORMED) |-> rsp_payload.out_last)
      else $error("malformed status without last");

   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out_status == lzsd_pkg::ST_MALFORMED) |->
      (rsp_payload.out_byte == 8'd0))
      else $error("malformed status carries data");

   a_exhausted_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out_status == lzsd_pkg::ST_EXHAUSTED) |-> rsp_payload.out_last)
      else $error("exhausted status without last");

   a_reset_no_rsp: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result presented right after reset");
`endif

endmodule
